@@ rtl/fingerprint_pattern_filter_top_macros.svh @@
// Assertion macros for the fingerprint pattern filter checker
`ifndef FINGERPRINT_PATTERN_FILTER_TOP_MACROS_SVH
`define FINGERPRINT_PATTERN_FILTER_TOP_MACROS_SVH

// checked only while out of reset
`define FPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/fpf_pkg.sv @@
// Constants, register codes and helpers for the fingerprint pattern filter
package fpf_pkg;

    localparam int PATTERN_CHARS = 8;
    localparam int MAX_FP_CHARS  = 512;

    localparam int CHAR_W  = 8;
    localparam int TEXT_W  = 64;
    localparam int CNT_W   = 4;
    localparam int TOTAL_W = 32;
    localparam int POS_W   = $clog2(MAX_FP_CHARS + 1);
    localparam int WIN_W   = CHAR_W * PATTERN_CHARS;
    localparam int IDX_W   = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
    localparam int ADDR_W  = 3;

    localparam logic [CNT_W-1:0] PAT_LEN  = CNT_W'(PATTERN_CHARS);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FP_CHARS);

    typedef enum logic [ADDR_W-1:0] {
        REG_PREFIX_TEXT  = 3'd0,
        REG_PREFIX_COUNT = 3'd1,
        REG_INFIX_TEXT   = 3'd2,
        REG_INFIX_COUNT  = 3'd3,
        REG_FOLD_CASE    = 3'd4
    } t_cfg_reg;

    // upper-case ASCII letters map onto lower case when folding is on
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        logic [CHAR_W-1:0] r;
        r = c;
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] n);
        return (n > PAT_LEN) ? PAT_LEN : n;
    endfunction

endpackage

@@ rtl/fingerprint_pattern_filter_top.sv @@
// Fingerprint pattern filter: prefix check and infix search over a character stream
// A verdict is registered in the result register when its last character leaves the input register.
// Throughput: one character per cycle; the input register and the result register
// are separate, so characters keep flowing while a verdict waits to be taken.
// Only a last character stalls, and only while an earlier verdict is still held.
// Reset (synchronous, active low) clears configuration, per-fingerprint state and count.
module fingerprint_pattern_filter_top
    import fpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_addr,
    input  logic [TEXT_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAR_W-1:0]   i_fp_char,
    input  logic                i_fp_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic [TOTAL_W-1:0]  o_checked_total
);

    // configuration
    logic [TEXT_W-1:0]  r_prefix_text;
    logic [CNT_W-1:0]   r_prefix_count;
    logic [TEXT_W-1:0]  r_infix_text;
    logic [CNT_W-1:0]   r_infix_count;
    logic               r_fold_case;

    // input register
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_last;

    // per-fingerprint state
    logic [POS_W-1:0]   r_pos;
    logic               r_prefix_ok;
    logic [WIN_W-1:0]   r_window;
    logic               r_infix_seen;
    logic [TOTAL_W-1:0] r_counter;

    // result register
    logic               r_out_valid;
    logic               r_out_accepted;
    logic [TOTAL_W-1:0] r_out_total;

    logic               out_free;
    logic               fire;
    logic [CNT_W-1:0]   pl;
    logic [CNT_W-1:0]   il;
    logic [POS_W-1:0]   n_pos;
    logic               n_prefix_ok;
    logic [WIN_W-1:0]   n_window;
    logic               n_infix_seen;
    logic               verdict;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || !r_in_last || out_free;

    assign pl = clamp_len(r_prefix_count);
    assign il = clamp_len(r_infix_count);

    always_comb begin
        logic [CNT_W-1:0]  k;
        logic [CHAR_W-1:0] w;
        logic              hit;
        logic [POS_W-1:0]  pos_inc;
        logic [WIN_W-1:0]  win_sh;
        logic              prefix_bad;

        pos_inc    = r_pos + POS_W'(1);
        win_sh     = WIN_W'({r_window, r_in_char});
        prefix_bad = (r_pos < POS_W'(pl)) &&
                     (fold_char(r_in_char, r_fold_case) !=
                      fold_char(r_prefix_text[8*r_pos[2:0] +: 8], r_fold_case));

        // window holds the newest character in its lowest byte
        hit = 1'b1;
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            k = il - CNT_W'(1) - CNT_W'(i);
            w = win_sh[8*k[IDX_W-1:0] +: 8];
            if (CNT_W'(i) < il &&
                fold_char(w, r_fold_case) !=
                fold_char(r_infix_text[8*i +: 8], r_fold_case)) begin
                hit = 1'b0;
            end
        end

        n_pos        = r_pos;
        n_prefix_ok  = r_prefix_ok;
        n_window     = r_window;
        n_infix_seen = r_infix_seen;
        // characters past the length limit leave the checks untouched
        if (r_pos < POS_LIMIT) begin
            n_pos       = pos_inc;
            n_window    = win_sh;
            n_prefix_ok = r_prefix_ok && !prefix_bad;
            if (il != '0 && pos_inc >= POS_W'(il) && hit) begin
                n_infix_seen = 1'b1;
            end
        end

        verdict = ((pl == '0) || (n_prefix_ok && n_pos >= POS_W'(pl))) &&
                  ((il == '0) || n_infix_seen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_text  <= '0;
            r_prefix_count <= '0;
            r_infix_text   <= '0;
            r_infix_count  <= '0;
            r_fold_case    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_PREFIX_TEXT:  r_prefix_text  <= i_cfg_wdata;
                REG_PREFIX_COUNT: r_prefix_count <= i_cfg_wdata[CNT_W-1:0];
                REG_INFIX_TEXT:   r_infix_text   <= i_cfg_wdata;
                REG_INFIX_COUNT:  r_infix_count  <= i_cfg_wdata[CNT_W-1:0];
                REG_FOLD_CASE:    r_fold_case    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_fp_char;
            r_in_last <= i_fp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_prefix_ok  <= 1'b1;
            r_window     <= '0;
            r_infix_seen <= 1'b0;
            r_counter    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire && r_in_last) begin
                r_pos        <= '0;
                r_prefix_ok  <= 1'b1;
                r_window     <= '0;
                r_infix_seen <= 1'b0;
                r_counter    <= r_counter + TOTAL_W'(1);
                r_out_valid  <= 1'b1;
            end else begin
                if (fire) begin
                    r_pos        <= n_pos;
                    r_prefix_ok  <= n_prefix_ok;
                    r_window     <= n_window;
                    r_infix_seen <= n_infix_seen;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out_accepted <= verdict;
            r_out_total    <= r_counter + TOTAL_W'(1);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_checked_total = r_out_total;

endmodule

@@ rtl/fpf_checker.sv @@
// Port-level checker for the fingerprint pattern filter, bound to the top level
`include "fingerprint_pattern_filter_top_macros.svh"

module fpf_checker
    import fpf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_accepted,
    input logic [TOTAL_W-1:0]  o_checked_total
);

    logic [TOTAL_W-1:0] r_prev_total;
    logic               out_xfer;

    assign out_xfer = o_out_valid && i_out_ready;

    // total seen on the previous result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total <= '0;
        end else if (out_xfer) begin
            r_prev_total <= o_checked_total;
        end
    end

    `FPF_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_accepted) && $stable(o_checked_total), "result changed while stalled")
    `FPF_ASSERT(a_total_step, out_xfer |-> o_checked_total == r_prev_total + TOTAL_W'(1), "checked total did not advance by one")
    `FPF_ASSERT(a_idle_ready, i_in_valid && !o_out_valid |-> o_in_ready, "input stalled with no result pending")
    `FPF_ASSERT(a_out_known, o_out_valid |-> !$isunknown({o_accepted, o_checked_total}), "result fields unknown while valid")
    `FPF_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind fingerprint_pattern_filter_top fpf_checker u_fpf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_accepted      (o_accepted),
    .o_checked_total (o_checked_total)
);
